### rtl/lrcs_pkg.sv
// Package for the LED ring crossfade sequencer: shared types, constants,
// color tables and position helpers. No dependencies.
`timescale 1ns / 1ps

package lrcs_pkg;

  localparam int LED_COUNT = 9;
  localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_NUM_W = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [3:0] RAINBOW_SIZE = 4'd7;
  localparam logic [3:0] GREEN_SIZE   = 4'd10;

  localparam logic [15:0] TRANSITION_RST = 16'd250;
  localparam logic [6:0]  DIRECTION_RST  = 7'd50;
  localparam logic [6:0]  MODE_RST       = 7'd100;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_TRANSITION = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_MODE       = 2'd2;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [15:0] fade_ms;
    logic [6:0]  direction_period;
    logic [6:0]  mode_period;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AMOUNT,
    ST_DIVIDE,
    ST_LEDS,
    ST_COUNT,
    ST_MODCHK,
    ST_SWAP
  } state_e;

  typedef struct packed {
    logic load;      // item accepted: update timer, latch step flag
    logic amt_go;    // saturate amount or start amount division
    logic amt_take;  // latch quotient as amount
    logic led_go;    // blend one LED into the output register
    logic cnt_go;    // bump step count, start direction check
    logic mod_take;  // latch direction check result
    logic swap_go;   // table swap check
  } cmd_t;

  typedef struct packed {
    logic step;
    logic bypass;
    logic div_done;
    logic slot_free;
    logic last_led;
    logic dir_zero;
  } sts_t;

  function automatic rgb_t table_color(input logic rainbow, input logic [3:0] pos);
    rgb_t c;
    if (rainbow) begin
      case (pos)
        4'd1:    c = '{8'd255, 8'd165, 8'd0};
        4'd2:    c = '{8'd255, 8'd255, 8'd0};
        4'd3:    c = '{8'd0,   8'd128, 8'd0};
        4'd4:    c = '{8'd0,   8'd0,   8'd255};
        4'd5:    c = '{8'd75,  8'd0,   8'd130};
        4'd6:    c = '{8'd238, 8'd130, 8'd238};
        default: c = '{8'd255, 8'd0,   8'd0};
      endcase
    end else begin
      case (pos)
        4'd1:    c = '{8'd0, 8'd75,  8'd0};
        4'd2:    c = '{8'd0, 8'd100, 8'd0};
        4'd3:    c = '{8'd0, 8'd125, 8'd0};
        4'd4:    c = '{8'd0, 8'd150, 8'd0};
        4'd5:    c = '{8'd0, 8'd175, 8'd0};
        4'd6:    c = '{8'd0, 8'd200, 8'd25};
        4'd7:    c = '{8'd0, 8'd225, 8'd50};
        4'd8:    c = '{8'd0, 8'd250, 8'd75};
        4'd9:    c = '{8'd0, 8'd255, 8'd100};
        default: c = '{8'd0, 8'd50,  8'd0};
      endcase
    end
    return c;
  endfunction

  // position modulo table size, for any 4-bit position
  function automatic logic [3:0] pos_reduce(input logic [3:0] pos, input logic rainbow);
    logic [3:0] p;
    if (rainbow) begin
      if (pos >= 4'd14)              p = pos - 4'd14;
      else if (pos >= RAINBOW_SIZE)  p = pos - RAINBOW_SIZE;
      else                           p = pos;
    end else begin
      if (pos >= GREEN_SIZE) p = pos - GREEN_SIZE;
      else                   p = pos;
    end
    return p;
  endfunction

  function automatic logic [3:0] pos_next(input logic [3:0] pos, input logic rainbow,
                                          input logic fwd);
    logic [3:0] last;
    logic [3:0] p;
    last = (rainbow ? RAINBOW_SIZE : GREEN_SIZE) - 4'd1;
    if (fwd) p = (pos == last) ? 4'd0 : pos + 4'd1;
    else     p = (pos == 4'd0) ? last : pos - 4'd1;
    return p;
  endfunction

endpackage

### rtl/lrcs_if.sv
// Stream interfaces for the crossfade sequencer: tick input and LED color output.
// Depends on lrcs_pkg.
`timescale 1ns / 1ps

interface lrcs_in_if import lrcs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ms_elapsed;

  modport source (output valid, output ms_elapsed, input ready);
  modport sink   (input valid, input ms_elapsed, output ready);
endinterface

interface lrcs_out_if import lrcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LED_NUM_W-1:0] led_number;
  logic [7:0]           red_level;
  logic [7:0]           green_level;
  logic [7:0]           blue_level;
  logic                 frame_end;

  modport source (output valid, output led_number, output red_level, output green_level,
                  output blue_level, output frame_end, input ready);
  modport sink   (input valid, input led_number, input red_level, input green_level,
                  input blue_level, input frame_end, output ready);
endinterface

### rtl/lrcs_divider.sv
// Restoring divider, one quotient bit per cycle, eight bits per run.
// Shared by the fade amount and the direction check. Depends on lrcs_pkg.
`timescale 1ns / 1ps

module lrcs_divider import lrcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,   // requires num_i[23:8] < den_i
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [7:0]  quot_o,
  output logic [15:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] den_q, den_d;
  logic [16:0] trial;
  logic        take;

  assign trial = {rem_q, low_q[7]};
  assign take  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      rem_d  = num_i[23:8];
      low_d  = num_i[7:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = take ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      low_d = {low_q[6:0], take};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = low_q;
  assign rem_o  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

endmodule

### rtl/lrcs_ctrl.sv
// Sequencer controller: item accept, amount, LED sweep and step bookkeeping.
// Depends on lrcs_pkg.
`timescale 1ns / 1ps

module lrcs_ctrl import lrcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_AMOUNT;
      ST_AMOUNT: state_d = sts_i.bypass ? ST_LEDS : ST_DIVIDE;
      ST_DIVIDE: if (sts_i.div_done) state_d = ST_LEDS;
      ST_LEDS:   if (sts_i.slot_free && sts_i.last_led) state_d = ST_COUNT;
      ST_COUNT: begin
        if (!sts_i.step)         state_d = ST_IDLE;
        else if (sts_i.dir_zero) state_d = ST_SWAP;
        else                     state_d = ST_MODCHK;
      end
      ST_MODCHK: if (sts_i.div_done) state_d = ST_SWAP;
      ST_SWAP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_AMOUNT: cmd_o.amt_go   = 1'b1;
      ST_DIVIDE: cmd_o.amt_take = sts_i.div_done;
      ST_LEDS:   cmd_o.led_go   = sts_i.slot_free;
      ST_COUNT:  cmd_o.cnt_go   = sts_i.step;
      ST_MODCHK: cmd_o.mod_take = sts_i.div_done;
      ST_SWAP:   cmd_o.swap_go  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_sweep_ends_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEDS && sts_i.slot_free && sts_i.last_led) |=> (state_q == ST_COUNT))
    else $error("LED sweep did not close");

endmodule

### rtl/lrcs_datapath.sv
// Sequencer datapath: timer, color walk state, LED color shift lines, blend
// and output register. Depends on lrcs_pkg and lrcs_divider.
`timescale 1ns / 1ps

module lrcs_datapath import lrcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [7:0]           ms_elapsed_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [LED_NUM_W-1:0] led_number_o,
  output logic [7:0]           red_level_o,
  output logic [7:0]           green_level_o,
  output logic [7:0]           blue_level_o,
  output logic                 frame_end_o
);

  localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(LED_COUNT - 1);

  function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] amt);
    logic [8:0]  wa;
    logic [8:0]  wb;
    logic [16:0] v;
    wa = 9'd256 - {1'b0, amt};
    wb = {1'b0, amt} + 9'd1;
    v  = {9'd0, a} * {8'd0, wa} + {9'd0, b} * {8'd0, wb};
    return v[15:8];
  endfunction

  // walk and timer state
  logic [15:0]          timer_q;
  logic [3:0]           pos_q;
  logic                 fwd_q;
  logic                 rainbow_q;
  logic [6:0]           count_q;
  logic                 step_q;
  logic [7:0]           amt_q;
  logic [LED_IDX_W-1:0] led_q;

  // per-LED colors, rotated once per LED so the head is the LED in work
  rgb_t start_q  [LED_COUNT];
  rgb_t target_q [LED_COUNT];
  rgb_t shown_q  [LED_COUNT];

  // output register
  logic                 out_valid_q;
  logic [LED_NUM_W-1:0] out_num_q;
  rgb_t                 out_rgb_q;
  logic                 out_end_q;

  logic [16:0] sum;
  logic [15:0] timer_sat;
  logic        step_now;
  logic        bypass;
  logic [23:0] prod;
  logic [6:0]  cnt_inc;
  logic        slot_free;
  logic        last_led;
  logic [3:0]  pos_cur;
  rgb_t        new_start;
  rgb_t        new_target;
  rgb_t        new_shown;

  logic        div_start;
  logic [23:0] div_num;
  logic [15:0] div_den;
  logic        div_done;
  logic [7:0]  div_quot;
  logic [15:0] div_rem;

  assign sum       = {1'b0, timer_q} + {9'd0, ms_elapsed_i};
  assign timer_sat = sum[16] ? 16'hFFFF : sum[15:0];
  assign step_now  = timer_sat >= cfg_i.fade_ms;
  assign bypass    = timer_q >= cfg_i.fade_ms;
  assign prod      = {timer_q, 8'd0} - {8'd0, timer_q};   // timer * 255
  assign cnt_inc   = count_q + 7'd1;
  assign slot_free = !out_valid_q || out_ready_i;
  assign last_led  = led_q == LAST_LED;

  assign pos_cur    = pos_reduce(pos_q, rainbow_q);
  assign new_start  = step_q ? shown_q[0] : start_q[0];
  assign new_target = step_q ? table_color(rainbow_q, pos_cur) : target_q[0];
  assign new_shown  = '{mix8(new_start.r, new_target.r, amt_q),
                        mix8(new_start.g, new_target.g, amt_q),
                        mix8(new_start.b, new_target.b, amt_q)};

  assign div_start = (cmd_i.amt_go && !bypass) ||
                     (cmd_i.cnt_go && (cfg_i.direction_period != 7'd0));
  assign div_num   = cmd_i.cnt_go ? {17'd0, cnt_inc} : prod;
  assign div_den   = cmd_i.cnt_go ? {9'd0, cfg_i.direction_period} : cfg_i.fade_ms;

  lrcs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q   <= 16'd0;
      pos_q     <= 4'd0;
      fwd_q     <= 1'b1;
      rainbow_q <= 1'b1;
      count_q   <= 7'd0;
      step_q    <= 1'b0;
      amt_q     <= 8'd0;
      led_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        step_q  <= step_now;
        timer_q <= step_now ? 16'd0 : timer_sat;
      end
      if (cmd_i.amt_go && bypass) amt_q <= 8'hFF;
      if (cmd_i.amt_take)         amt_q <= div_quot;
      if (cmd_i.led_go) begin
        led_q <= last_led ? '0 : led_q + LED_IDX_W'(1);
        if (step_q) pos_q <= pos_next(pos_cur, rainbow_q, fwd_q);
      end
      if (cmd_i.cnt_go)                            count_q <= cnt_inc;
      if (cmd_i.mod_take && (div_rem == 16'd0))    fwd_q   <= !fwd_q;
      if (cmd_i.swap_go && step_q && (count_q == cfg_i.mode_period)) begin
        rainbow_q <= !rainbow_q;
        count_q   <= 7'd0;
        pos_q     <= pos_reduce(pos_q, !rainbow_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        start_q[i]  <= '0;
        target_q[i] <= '0;
        shown_q[i]  <= '0;
      end
    end else if (cmd_i.led_go) begin
      for (int i = 0; i < LED_COUNT - 1; i++) begin
        start_q[i]  <= start_q[i+1];
        target_q[i] <= target_q[i+1];
        shown_q[i]  <= shown_q[i+1];
      end
      start_q[LED_COUNT-1]  <= new_start;
      target_q[LED_COUNT-1] <= new_target;
      shown_q[LED_COUNT-1]  <= new_shown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.led_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.led_go) begin
      out_num_q <= LED_NUM_W'(led_q);
      out_rgb_q <= new_shown;
      out_end_q <= last_led;
    end
  end

  assign sts_o.step      = step_q;
  assign sts_o.bypass    = bypass;
  assign sts_o.div_done  = div_done;
  assign sts_o.slot_free = slot_free;
  assign sts_o.last_led  = last_led;
  assign sts_o.dir_zero  = cfg_i.direction_period == 7'd0;

  assign out_valid_o   = out_valid_q;
  assign led_number_o  = out_num_q;
  assign red_level_o   = out_rgb_q.r;
  assign green_level_o = out_rgb_q.g;
  assign blue_level_o  = out_rgb_q.b;
  assign frame_end_o   = out_end_q;

  a_pos_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rainbow_q ? (pos_q < RAINBOW_SIZE) : (pos_q < GREEN_SIZE))
    else $error("table position outside active table");

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_end_q) |-> (out_num_q == LED_NUM_W'(LED_COUNT - 1)))
    else $error("frame end on wrong LED");

endmodule

### rtl/led_ring_color_crossfade_sequencer_unit.sv
// Top level of the LED ring crossfade sequencer: APB register file, controller
// and datapath. Depends on lrcs_pkg, lrcs_if, lrcs_ctrl and lrcs_datapath.
`timescale 1ns / 1ps

// Each input beat is a millisecond tick (ms_elapsed). It advances a saturating
// timer; when the timer reaches fade_ms a color step fires and every LED
// takes its next target from the rainbow or green table. Each beat then
// produces LED_COUNT output beats, LED 0 first, frame_end on the last one.
// Sequence per item: accept, amount setup, division by the eight-step restoring
// divider, LED sweep, count; the division is skipped when the amount is
// saturated (interval zero). A step item with a nonzero direction period then
// has the same divider check the step count against the direction period
// before the swap check; with a zero direction period a step item goes
// straight to the swap check. The LED sweep blends one LED per cycle and holds
// while the output register is full, so output back-pressure slows the sweep.
// A new item is taken only in idle, after the last LED sits in the output
// register and the count and swap bookkeeping is done. Registers (APB, 32-bit,
// byte addresses): 0x0 fade_ms, 0x4 direction_period, 0x8 mode_period; write
// only while idle.

module led_ring_color_crossfade_sequencer_unit import lrcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  lrcs_in_if.sink           item_i,
  lrcs_out_if.source        result_o
);

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [1:0] reg_idx;
  cmd_t       cmd;
  sts_t       sts;
  logic       in_ready;

  // register index from word address; low address bits ignored
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_ms          <= TRANSITION_RST;
      cfg_q.direction_period <= DIRECTION_RST;
      cfg_q.mode_period      <= MODE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_TRANSITION: cfg_q.fade_ms          <= pwdata[15:0];
        REG_DIRECTION:  cfg_q.direction_period <= pwdata[6:0];
        REG_MODE:       cfg_q.mode_period      <= pwdata[6:0];
        default: ;      // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRANSITION: prdata = {16'd0, cfg_q.fade_ms};
      REG_DIRECTION:  prdata = {25'd0, cfg_q.direction_period};
      REG_MODE:       prdata = {25'd0, cfg_q.mode_period};
      default:        prdata = '0;
    endcase
  end

  lrcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign item_i.ready = in_ready;

  lrcs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ms_elapsed_i  (item_i.ms_elapsed),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .led_number_o  (result_o.led_number),
    .red_level_o   (result_o.red_level),
    .green_level_o (result_o.green_level),
    .blue_level_o  (result_o.blue_level),
    .frame_end_o   (result_o.frame_end)
  );

endmodule
